// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the heater phase controller.
// Defining ASSERT_OFF removes every checker from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Concurrent property sampled on the rising clock, ignored while reset is high.
`define ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("assertion failed");

// Concurrent property that also holds during reset.
`define ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clock, reset, prop)
`define ASSERT_ALWAYS(label, clock, prop)

`endif

`endif

// ===== rtl/shpc_pkg.sv =====
// Types, codes and helper functions of the staged heater phase controller.
// No dependencies.
package shpc_pkg;

  typedef enum logic [2:0] {
    STAGE_IDLE  = 3'd0,
    STAGE_ONE   = 3'd1,
    STAGE_TWO   = 3'd2,
    STAGE_THREE = 3'd3,
    STAGE_DONE  = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_ONE  = 2'd1,
    CH_TWO  = 2'd2
  } channel_t;

  typedef enum logic [2:0] {
    REG_STAGE_ONE_LIMIT   = 3'd0,
    REG_STAGE_TWO_LIMIT   = 3'd1,
    REG_STAGE_THREE_LIMIT = 3'd2,
    REG_STAGE_TWO_START   = 3'd3,
    REG_STAGE_THREE_START = 3'd4,
    REG_FINISH_TIME       = 3'd5,
    REG_HALF_CYCLES       = 3'd6
  } reg_index_t;

  localparam int TEMP_W    = 8;
  localparam int DELAY_W   = 18;
  localparam int POWER_W   = 7;
  localparam int SEC_W     = 12;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 48;

  localparam logic [SEC_W-1:0]   SEC_WRAP         = 12'd3600;
  localparam logic [TEMP_W-1:0]  RST_STAGE1_LIMIT = 8'd50;
  localparam logic [TEMP_W-1:0]  RST_STAGE2_LIMIT = 8'd30;
  localparam logic [TEMP_W-1:0]  RST_STAGE3_LIMIT = 8'd78;
  localparam logic [SEC_W-1:0]   RST_STAGE2_START = 12'd300;
  localparam logic [SEC_W-1:0]   RST_STAGE3_START = 12'd600;
  localparam logic [SEC_W-1:0]   RST_FINISH_TIME  = 12'd900;
  localparam logic [COUNT_W-1:0] RST_HALF_CYCLES  = 7'd100;
  localparam logic [COUNT_W-1:0] RST_CROSSINGS    = 7'd99;
  localparam logic [TEMP_W-1:0]  RST_ACTIVE_LIMIT = 8'd78;

  // Result fields; the last member sits in the lowest bits.
  typedef struct packed {
    logic                 sampled;
    logic [SEC_W-1:0]     elapsed_seconds;
    logic [POWER_W-1:0]   power_percent;
    stage_t               process_stage;
    logic [DELAY_W-1:0]   fire_delay_cycles;
    channel_t             fire_channel;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [DELAY_W-1:0] cycles;
  } delay_t;

  // Firing delay for the held power; levels outside the table do not fire.
  function automatic delay_t delay_for_power(input logic [POWER_W-1:0] p);
    delay_t d;
    d.valid  = 1'b1;
    d.cycles = '0;
    unique case (p)
      7'd100:  d.cycles = 18'd0;
      7'd90:   d.cycles = 18'd36800;
      7'd80:   d.cycles = 18'd52800;
      7'd70:   d.cycles = 18'd65600;
      7'd60:   d.cycles = 18'd73600;
      7'd50:   d.cycles = 18'd86400;
      default: d.valid  = 1'b0;
    endcase
    return d;
  endfunction

  // Power in 5-degree bands below the limit.
  function automatic logic [POWER_W-1:0] band_power(input logic [TEMP_W-1:0] temp,
                                                    input logic [TEMP_W-1:0] lim);
    logic [TEMP_W-1:0]  diff;
    logic [POWER_W-1:0] p;
    diff = lim - temp;
    priority if (lim < 8'd25)   p = 7'd0;
    else if (temp > lim)        p = 7'd0;
    else if (diff < 8'd5)       p = 7'd50;
    else if (diff < 8'd10)      p = 7'd60;
    else if (diff < 8'd15)      p = 7'd70;
    else if (diff < 8'd20)      p = 7'd80;
    else if (diff < 8'd25)      p = 7'd90;
    else                        p = 7'd100;
    return p;
  endfunction

endpackage

// ===== rtl/staged_heater_phase_controller_unit.sv =====
// Top level of the staged heater phase controller: stage sequencing, power bands
// and firing decision per mains zero crossing. Depends on shpc_pkg and assert_macros.svh.
// A result is registered and is on the master side in the cycle after its input transaction.
// Throughput: one crossing per cycle; the single output register holds a result
// while the next crossing is taken whenever that register is emptied in the same cycle.
// Reset (rst, synchronous): all registers but the result register return to their defaults, stage 0, power 0.
`include "assert_macros.svh"

module staged_heater_phase_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [shpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shpc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [shpc_pkg::IN_W-1:0]      s_axis_tdata,  // [7:0] heater_temp
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] fire_channel, [19:2] fire_delay_cycles, [22:20] process_stage,
  // [29:23] power_percent, [41:30] elapsed_seconds, [42] sampled, [47:43] zero
  output logic [shpc_pkg::OUT_W-1:0]     m_axis_tdata
);
  import shpc_pkg::*;

  logic [TEMP_W-1:0]  stage_one_limit;
  logic [TEMP_W-1:0]  stage_two_limit;
  logic [TEMP_W-1:0]  stage_three_limit;
  logic [SEC_W-1:0]   stage_two_start;
  logic [SEC_W-1:0]   stage_three_start;
  logic [SEC_W-1:0]   finish_time;
  logic [COUNT_W-1:0] half_cycles;

  stage_t             stage_reg, stage_reg_next;
  logic [POWER_W-1:0] power_reg, power_reg_next;
  logic [TEMP_W-1:0]  active_limit, active_limit_next;
  logic [COUNT_W-1:0] crossing_count, crossing_count_next;
  logic [SEC_W-1:0]   second_count, second_count_next;

  result_t            result, result_next;
  logic               out_valid;

  logic [TEMP_W-1:0]  temp;
  logic [COUNT_W-1:0] period;
  logic               update;
  delay_t             held_delay;
  channel_t           chan;
  logic               sampled;
  logic               accept;

  assign temp          = s_axis_tdata[TEMP_W-1:0];
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, result};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_one_limit   <= RST_STAGE1_LIMIT;
      stage_two_limit   <= RST_STAGE2_LIMIT;
      stage_three_limit <= RST_STAGE3_LIMIT;
      stage_two_start   <= RST_STAGE2_START;
      stage_three_start <= RST_STAGE3_START;
      finish_time       <= RST_FINISH_TIME;
      half_cycles       <= RST_HALF_CYCLES;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_STAGE_ONE_LIMIT:   stage_one_limit   <= cfg_data[TEMP_W-1:0];
        REG_STAGE_TWO_LIMIT:   stage_two_limit   <= cfg_data[TEMP_W-1:0];
        REG_STAGE_THREE_LIMIT: stage_three_limit <= cfg_data[TEMP_W-1:0];
        REG_STAGE_TWO_START:   stage_two_start   <= cfg_data[SEC_W-1:0];
        REG_STAGE_THREE_START: stage_three_start <= cfg_data[SEC_W-1:0];
        REG_FINISH_TIME:       finish_time       <= cfg_data[SEC_W-1:0];
        REG_HALF_CYCLES:       half_cycles       <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Firing decision uses the stage and power held before this crossing.
  always_comb begin
    held_delay = delay_for_power(power_reg);
    unique case (stage_reg)
      STAGE_ONE, STAGE_TWO: chan = CH_ONE;
      STAGE_THREE:          chan = CH_TWO;
      default:              chan = CH_NONE;
    endcase
    if (!held_delay.valid) begin
      chan = CH_NONE;
    end
  end

  // A zero period counts as one, so every crossing then updates.
  assign period = (half_cycles == '0) ? COUNT_W'(1) : half_cycles;
  assign update = crossing_count >= (period - COUNT_W'(1));

  always_comb begin
    stage_reg_next      = stage_reg;
    power_reg_next      = power_reg;
    active_limit_next   = active_limit;
    crossing_count_next = crossing_count + COUNT_W'(1);
    second_count_next   = second_count;
    sampled             = 1'b0;
    if (update) begin
      crossing_count_next = '0;
      second_count_next   = (second_count >= SEC_WRAP) ? '0 : second_count + SEC_W'(1);
      if (stage_reg != STAGE_DONE) begin
        if (stage_reg == STAGE_IDLE) begin
          active_limit_next = stage_one_limit;
          stage_reg_next    = STAGE_ONE;
        end
        priority if (second_count_next == stage_two_start) begin
          active_limit_next = stage_two_limit;
          stage_reg_next    = STAGE_TWO;
        end else if (second_count_next == stage_three_start) begin
          active_limit_next = stage_three_limit;
          stage_reg_next    = STAGE_THREE;
        end else if (second_count_next == finish_time) begin
          stage_reg_next = STAGE_DONE;
        end else begin
        end
        if (stage_reg_next != STAGE_DONE) begin
          power_reg_next = band_power(temp, active_limit_next);
          sampled        = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result_next.fire_channel      = chan;
    result_next.fire_delay_cycles = (chan == CH_NONE) ? '0 : held_delay.cycles;
    result_next.process_stage     = stage_reg_next;
    result_next.power_percent     = power_reg_next;
    result_next.elapsed_seconds   = second_count_next;
    result_next.sampled           = sampled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg      <= STAGE_IDLE;
      power_reg      <= '0;
      active_limit   <= RST_ACTIVE_LIMIT;
      crossing_count <= RST_CROSSINGS;
      second_count   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        stage_reg      <= stage_reg_next;
        power_reg      <= power_reg_next;
        active_limit   <= active_limit_next;
        crossing_count <= crossing_count_next;
        second_count   <= second_count_next;
        out_valid      <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  `ASSERT_CLK(a_no_fire_no_delay, clk, rst, (out_valid && result.fire_channel == CH_NONE) |-> (result.fire_delay_cycles == '0))
  `ASSERT_CLK(a_sampled_stage, clk, rst, (out_valid && result.sampled) |-> (result.process_stage == STAGE_ONE || result.process_stage == STAGE_TWO || result.process_stage == STAGE_THREE))
  `ASSERT_CLK(a_seconds_range, clk, rst, second_count <= SEC_WRAP)
  `ASSERT_CLK(a_done_terminal, clk, rst, (stage_reg == STAGE_DONE) |=> (stage_reg == STAGE_DONE))
  `ASSERT_CLK(a_accept_fills_output, clk, rst, accept |=> out_valid)

endmodule
